// File: sv/pcxrle_pkg.sv
// Shared types and constants of the PCX run-length palette decoder.
`timescale 1ns / 1ps
`default_nettype none

package pcxrle_pkg;

    // Field widths of the stream and configuration channels.
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 16;
    localparam int RGB_W       = 3 * BYTE_W;
    localparam int RUN_W       = 6;
    localparam int S_TDATA_W   = 5 * BYTE_W;
    localparam int M_TDATA_W   = RGB_W + 2 * COORD_W;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    // Byte codes of the encoded stream.
    localparam logic [BYTE_W-1:0] RUN_HDR_MIN = 8'hC0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_ENABLE = 8'd3;

    // Input item kinds carried on the slave tuser bit.
    localparam logic MODE_PIXEL   = 1'b0;
    localparam logic MODE_PALETTE = 1'b1;

    // Result status carried on the master tuser bit.
    localparam logic STATUS_PIXEL = 1'b0;
    localparam logic STATUS_TRUNC = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_EMIT = 4'b0100,
        S_ERR  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// File: sv/pcx_rle_scanline_palette_decoder_core.sv
// Top level of the PCX run-length scanline decoder with an 8-bit palette lookup.
// A palette write or a run header is taken in idle; a literal byte goes through accept,
// palette read and emit; a run value byte goes the same way and places its clipped length
// in emit. A truncation report goes through the error state. The rate is set by the single
// palette RAM read per byte and one placed position per cycle while i_m_tready does not stall it.
// Reset (i_rst_n low, synchronous) restores the control registers, clears the decode position and halt.
`timescale 1ns / 1ps
`default_nettype none

module pcx_rle_scanline_palette_decoder_core #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Configuration write channel.
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [pcxrle_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pcxrle_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream.
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // tdata from bit 0: data_byte, entry_index, entry_red, entry_green, entry_blue
    input  wire logic [pcxrle_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  wire logic                                 i_s_tlast,  // end_of_data
    input  wire logic                                 i_s_tuser,  // mode
    // Result stream.
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // tdata from bit 0: red, green, blue, column, line_number
    output logic      [pcxrle_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                                      o_m_tlast,  // last
    output logic                                      o_m_tuser   // status
);

    import pcxrle_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    // ------------------------------------------------------------------
    // Input field unpacking.
    // ------------------------------------------------------------------
    logic              in_mode;
    logic [BYTE_W-1:0] in_byte;
    logic [BYTE_W-1:0] in_idx;
    logic [RGB_W-1:0]  in_rgb;
    logic              s_accept;
    logic              idx_ok;

    assign in_mode  = i_s_tuser;
    assign in_byte  = i_s_tdata[7:0];
    assign in_idx   = i_s_tdata[15:8];
    // Palette words are stored red in the top byte, blue in the bottom byte.
    assign in_rgb   = {i_s_tdata[23:16], i_s_tdata[31:24], i_s_tdata[39:32]};
    assign s_accept = i_s_tvalid & o_s_tready;
    assign idx_ok   = {1'b0, in_idx} < 9'(PALETTE_ENTRIES);

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [COORD_W-1:0] r_width, n_width;
    logic [COORD_W-1:0] r_lbytes, n_lbytes;
    logic [COORD_W-1:0] r_height, n_height;
    logic               r_pal_en, n_pal_en;
    logic               r_run_pending, n_run_pending;
    logic [RUN_W-1:0]   r_run_count, n_run_count;
    logic [COORD_W-1:0] r_pos, n_pos;
    logic [COORD_W-1:0] r_line, n_line;
    logic               r_halted, n_halted;
    logic [RUN_W-1:0]   r_remain, n_remain;
    logic               r_eod, n_eod;
    logic               r_out_valid, n_out_valid;
    // Payload registers: no reset needed.
    logic [BYTE_W-1:0]    r_byte, n_byte;
    logic [RGB_W-1:0]     r_rgb, n_rgb;
    logic [M_TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic                 r_out_last, n_out_last;
    logic                 r_out_status, n_out_status;

    // ------------------------------------------------------------------
    // Palette memory. Writes come from palette items accepted in idle and
    // reads are issued when a pixel byte is accepted, so a read never meets
    // a write to the same entry in the same cycle and needs no forwarding.
    // ------------------------------------------------------------------
    logic [RGB_W-1:0] ram_q;

    pcxrle_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (s_accept & (in_mode == MODE_PALETTE) & idx_ok),
        .i_waddr (in_idx[AW-1:0]),
        .i_wdata (in_rgb),
        .i_re    (s_accept & (in_mode == MODE_PIXEL)),
        .i_raddr (in_byte[AW-1:0]),
        .o_rdata (ram_q)
    );

    // ------------------------------------------------------------------
    // Placement of one decoded byte at the current position. Zero line
    // and height registers behave as one.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] lb_eff;
    logic [COORD_W-1:0] lh_eff;
    logic [COORD_W:0]   pos_inc;
    logic [COORD_W:0]   line_inc;
    logic [COORD_W:0]   run_end;
    logic               wrap;
    logic               done_img;
    logic               done_run;
    logic               visible;
    logic               final_place;
    logic               more_vis;
    logic               err_follows;
    logic               pix_last;
    logic               slot_free;
    logic               color_in_range;
    logic [RGB_W-1:0]   color;

    assign lb_eff   = (r_lbytes == '0) ? COORD_W'(1) : r_lbytes;
    assign lh_eff   = (r_height == '0) ? COORD_W'(1) : r_height;
    assign pos_inc  = {1'b0, r_pos} + (COORD_W+1)'(1);
    assign line_inc = {1'b0, r_line} + (COORD_W+1)'(1);
    assign wrap     = pos_inc >= {1'b0, lb_eff};
    assign done_img = wrap && (line_inc >= {1'b0, lh_eff});
    assign visible  = r_pos < r_width;

    // The placements still due for this byte reach the end of the scanline
    // when they cover every position up to it; on the last scanline that
    // completes the image, and then no truncation report follows.
    assign run_end  = {1'b0, r_pos} + (COORD_W+1)'(r_remain);
    assign done_run = (run_end >= {1'b0, lb_eff}) && (line_inc >= {1'b0, lh_eff});

    // A run stops at the end of its scanline, so a wrap always ends the
    // placements of this byte. The next placement, if any, sits one column
    // further on the same line, so whether another pixel follows is known now.
    assign final_place = (r_remain == RUN_W'(1)) || wrap;
    assign more_vis    = !final_place && (pos_inc < {1'b0, r_width});
    assign err_follows = r_eod && !done_run;
    assign pix_last    = !more_vis && !err_follows;

    // The output register can take a new result when it is empty or when
    // its current result is being taken in this cycle.
    assign slot_free = !r_out_valid || i_m_tready;

    // Indexes beyond the palette read as black; with the palette disabled
    // the index itself is shown as a gray level.
    assign color_in_range = {1'b0, r_byte} < 9'(PALETTE_ENTRIES);
    assign color = r_pal_en ? (color_in_range ? ram_q : '0) : {r_byte, r_byte, r_byte};

    // ------------------------------------------------------------------
    // Next-state logic.
    // ------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_width       = r_width;
        n_lbytes      = r_lbytes;
        n_height      = r_height;
        n_pal_en      = r_pal_en;
        n_run_pending = r_run_pending;
        n_run_count   = r_run_count;
        n_pos         = r_pos;
        n_line        = r_line;
        n_halted      = r_halted;
        n_remain      = r_remain;
        n_eod         = r_eod;
        n_byte        = r_byte;
        n_rgb         = r_rgb;
        n_out_valid   = r_out_valid & ~i_m_tready;
        n_out_tdata   = r_out_tdata;
        n_out_last    = r_out_last;
        n_out_status  = r_out_status;

        // The user must send configuration writes only while the block is idle; the block does not enforce it.
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:    n_width  = i_cfg_data;
                CFG_LINE_BYTES:     n_lbytes = i_cfg_data;
                CFG_IMAGE_HEIGHT:   n_height = i_cfg_data;
                CFG_PALETTE_ENABLE: n_pal_en = i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                // Palette writes are fully handled by the RAM write port.
                if (s_accept && (in_mode == MODE_PIXEL) && !r_halted) begin
                    n_byte = in_byte;
                    n_eod  = i_s_tlast;
                    priority if (r_run_pending) begin
                        // Value byte of a run: repeat it run_count times, up to the scanline end.
                        n_run_pending = 1'b0;
                        n_run_count   = '0;
                        n_remain      = r_run_count;
                        n_state       = S_LOOK;
                    end else if (in_byte >= RUN_HDR_MIN) begin
                        n_run_pending = 1'b1;
                        n_run_count   = in_byte[RUN_W-1:0];
                        if (i_s_tlast) begin
                            n_state = S_ERR;
                        end
                    end else begin
                        n_remain = RUN_W'(1);
                        n_state  = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                // The palette word read at accept time is valid now.
                n_rgb   = color;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_remain == '0) begin
                    // A run of length zero places nothing.
                    n_state = r_eod ? S_ERR : S_IDLE;
                end else if (slot_free) begin
                    n_remain = RUN_W'(r_remain - RUN_W'(1));
                    if (visible) begin
                        n_out_valid  = 1'b1;
                        n_out_tdata  = {r_line, r_pos, r_rgb[7:0], r_rgb[15:8], r_rgb[23:16]};
                        n_out_last   = pix_last;
                        n_out_status = STATUS_PIXEL;
                    end
                    if (wrap) begin
                        n_pos = '0;
                        if (done_img) begin
                            n_halted = 1'b1;
                        end else begin
                            n_line = line_inc[COORD_W-1:0];
                        end
                    end else begin
                        n_pos = pos_inc[COORD_W-1:0];
                    end
                    if (final_place) begin
                        n_remain = '0;
                        n_state  = err_follows ? S_ERR : S_IDLE;
                    end
                end
            end
            S_ERR: begin
                // Truncated stream: report the position reached, then halt.
                if (slot_free) begin
                    n_out_valid   = 1'b1;
                    n_out_tdata   = {r_line, r_pos, RGB_W'(0)};
                    n_out_last    = 1'b1;
                    n_out_status  = STATUS_TRUNC;
                    n_halted      = 1'b1;
                    n_run_pending = 1'b0;
                    n_run_count   = '0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_width       <= COORD_W'(1);
            r_lbytes      <= COORD_W'(1);
            r_height      <= COORD_W'(1);
            r_pal_en      <= 1'b0;
            r_run_pending <= 1'b0;
            r_run_count   <= '0;
            r_pos         <= '0;
            r_line        <= '0;
            r_halted      <= 1'b0;
            r_remain      <= '0;
            r_eod         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_width       <= n_width;
            r_lbytes      <= n_lbytes;
            r_height      <= n_height;
            r_pal_en      <= n_pal_en;
            r_run_pending <= n_run_pending;
            r_run_count   <= n_run_count;
            r_pos         <= n_pos;
            r_line        <= n_line;
            r_halted      <= n_halted;
            r_remain      <= n_remain;
            r_eod         <= n_eod;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_rgb        <= n_rgb;
        r_out_tdata  <= n_out_tdata;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    // ------------------------------------------------------------------
    // Outputs. The input side is ready in idle even while a result still
    // waits in the output register.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_tdata;
    assign o_m_tlast   = r_out_last;
    assign o_m_tuser   = r_out_status;

endmodule

`default_nettype wire

// File: sv/pcxrle_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/pcxrle_checker.sv
// Port-level assertions for the PCX run-length decoder and their bind.
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [pcxrle_pkg::M_TDATA_W-1:0] o_m_tdata,
    input wire logic                             o_m_tlast,
    input wire logic                             o_m_tuser
);

    import pcxrle_pkg::*;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // A truncation report is black and ends the results of its item.
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == STATUS_TRUNC) |-> o_m_tlast && (o_m_tdata[23:0] == 24'd0))
        else $error("malformed truncation result");

    // After a truncation report the decoder is halted and stays silent.
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && (o_m_tuser == STATUS_TRUNC) |=> !o_m_tvalid)
        else $error("result after truncation");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind pcx_rle_scanline_palette_decoder_core pcxrle_checker u_checker (.*);

`default_nettype wire

// File: test/pcx_rle_scanline_palette_decoder_core_tb.sv
// Self-checking testbench of the PCX run-length scanline decoder: predicts and checks every pixel.
`timescale 1ns / 1ps

module pcx_rle_scanline_palette_decoder_core_tb;
    import pcxrle_pkg::*;

    localparam int PAL_ENTRIES  = 256;
    localparam int REST_CYCLES  = 100;      // longest run plus pipeline, with margin
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 25;
    localparam int LIMIT_CYCLES = 2_000_000;

    typedef struct packed {
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] line_number;
        logic               status;
        logic               last;
    } t_pixel;

    // Tracks the decoder state, predicts the pixels of every accepted input transaction
    // and compares the result transactions against them in order.
    class pcx_pixel_scoreboard;
        logic [COORD_W-1:0] width_reg;
        logic [COORD_W-1:0] lbytes_reg;
        logic [COORD_W-1:0] height_reg;
        logic               pal_en;
        logic [RGB_W-1:0]   palette [PAL_ENTRIES];
        logic               run_armed;
        logic [RUN_W-1:0]   run_len;
        logic [COORD_W-1:0] xpos;
        logic [COORD_W-1:0] ypos;
        logic               stopped;
        t_pixel             pending_pixels [$];
        t_pixel             fresh [$];
        int                 mismatches;
        int                 pixels_seen;
        int                 truncs_seen;

        function new();
            width_reg   = 16'd1;
            lbytes_reg  = 16'd1;
            height_reg  = 16'd1;
            pal_en      = 1'b0;
            run_armed   = 1'b0;
            run_len     = '0;
            xpos        = '0;
            ypos        = '0;
            stopped     = 1'b0;
            mismatches  = 0;
            pixels_seen = 0;
            truncs_seen = 0;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:    width_reg  = val;
                CFG_LINE_BYTES:     lbytes_reg = val;
                CFG_IMAGE_HEIGHT:   height_reg = val;
                CFG_PALETTE_ENABLE: pal_en     = val[0];
                default: ;
            endcase
        endfunction

        function void emit(logic [RGB_W-1:0] rgb, logic status);
            fresh.push_back('{red: rgb[2*BYTE_W +: BYTE_W], green: rgb[BYTE_W +: BYTE_W],
                              blue: rgb[0 +: BYTE_W], column: xpos, line_number: ypos,
                              status: status, last: 1'b0});
        endfunction

        // Places one decoded byte; returns 1 when it closed the scanline.
        function bit place_pixel(logic [BYTE_W-1:0] v);
            logic [RGB_W-1:0] rgb;
            int span;
            int rows;
            span = (lbytes_reg == 0) ? 1 : int'(lbytes_reg);
            rows = (height_reg == 0) ? 1 : int'(height_reg);
            if (xpos < width_reg) begin
                rgb = {v, v, v};
                if (pal_en)
                    rgb = (int'(v) < PAL_ENTRIES) ? palette[v] : '0;
                emit(rgb, STATUS_PIXEL);
            end
            if (int'(xpos) + 1 >= span) begin
                xpos = '0;
                if (int'(ypos) + 1 >= rows)
                    stopped = 1'b1;
                else
                    ypos = ypos + 1'b1;
                return 1'b1;
            end
            xpos = xpos + 1'b1;
            return 1'b0;
        endfunction

        function void take_input(logic mode, logic [S_TDATA_W-1:0] data, logic eod);
            logic [BYTE_W-1:0] code;
            logic [BYTE_W-1:0] slot;
            int i;
            code = data[0 +: BYTE_W];
            slot = data[BYTE_W +: BYTE_W];
            if (mode == MODE_PALETTE) begin
                if (int'(slot) < PAL_ENTRIES)
                    palette[slot] = {data[2*BYTE_W +: BYTE_W], data[3*BYTE_W +: BYTE_W],
                                     data[4*BYTE_W +: BYTE_W]};
                return;
            end
            if (stopped)
                return;
            if (run_armed) begin
                run_armed = 1'b0;
                // A run never spills into the next scanline.
                for (i = 0; i < int'(run_len) && !stopped; i++) begin
                    if (place_pixel(code))
                        break;
                end
                run_len = '0;
            end else if (code >= RUN_HDR_MIN) begin
                run_armed = 1'b1;
                run_len   = code[RUN_W-1:0];
            end else begin
                void'(place_pixel(code));
            end
            if (eod && !stopped) begin
                emit('0, STATUS_TRUNC);
                stopped   = 1'b1;
                run_armed = 1'b0;
                run_len   = '0;
            end
            if (fresh.size() > 0)
                fresh[fresh.size()-1].last = 1'b1;
            foreach (fresh[k])
                pending_pixels.push_back(fresh[k]);
            fresh.delete();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_pixel(logic [M_TDATA_W-1:0] data, logic tlast, logic tuser);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                $error("result with nothing expected: tdata=%h tlast=%b tuser=%b",
                       data, tlast, tuser);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("red", want.red, data[0 +: BYTE_W]);
            compare_field("green", want.green, data[BYTE_W +: BYTE_W]);
            compare_field("blue", want.blue, data[2*BYTE_W +: BYTE_W]);
            compare_field("column", want.column, data[RGB_W +: COORD_W]);
            compare_field("line_number", want.line_number, data[RGB_W+COORD_W +: COORD_W]);
            compare_field("status", want.status, tuser);
            compare_field("last", want.last, tlast);
            if (want.status == STATUS_TRUNC)
                truncs_seen++;
            else
                pixels_seen++;
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata   = '0;
    logic                   i_s_tlast   = 1'b0;
    logic                   i_s_tuser   = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;
    logic                   o_m_tlast;
    logic                   o_m_tuser;

    pcx_pixel_scoreboard sb = new();

    logic        steady  = 1'b0;   // both sides run without gaps while set
    logic        hold_on = 1'b0;   // receiver refuses results while set
    event        hold_kick;
    int          items_sent = 0;
    int          settings_applied = 0;
    int unsigned cycle_count = 0;

    pcx_rle_scanline_palette_decoder_core #(
        .PALETTE_ENTRIES(PAL_ENTRIES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: check every accepted transaction, then pick the next tready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_pixel(o_m_tdata, o_m_tlast, o_m_tuser);
        i_m_tready <= !hold_on && (steady || $urandom_range(0, 99) >= 22);
    end

    // Long receiver stall, timed here while the sender keeps offering bytes.
    initial begin : stall_window
        forever begin
            @(hold_kick);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    // Offers one input transaction and returns at the edge that accepted it. tvalid
    // stays high afterwards so back-to-back bytes never toggle it within a step.
    task automatic offer_byte(input logic mode, input logic [S_TDATA_W-1:0] data,
                              input logic eod);
        while (!steady && $urandom_range(0, 99) < 22) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= data;
        i_s_tlast  <= eod;
        do @(posedge i_clk); while (!o_s_tready);
        sb.take_input(mode, data, eod);
        items_sent++;
    endtask

    // Pixel stream byte; the palette fields ride along with random content.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eod);
        offer_byte(MODE_PIXEL, {32'($urandom), b}, eod);
    endtask

    task automatic send_run(input logic [RUN_W-1:0] cnt, input logic [BYTE_W-1:0] val);
        send_byte(RUN_HDR_MIN | {2'b00, cnt}, 1'b0);
        send_byte(val, 1'b0);
    endtask

    // Palette write; data_byte and end_of_data are don't-care here and get random values.
    task automatic send_palette(input logic [BYTE_W-1:0] idx, input logic [RGB_W-1:0] rgb);
        offer_byte(MODE_PALETTE, {rgb[0 +: BYTE_W], rgb[BYTE_W +: BYTE_W],
                                  rgb[2*BYTE_W +: BYTE_W], idx, 8'($urandom)},
                   1'($urandom));
    endtask

    // Stop offering, let every expected result drain, then give the block time to
    // finish a run that lands entirely in padding and so produces nothing.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (REST_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] lb,
                             input logic [COORD_W-1:0] h, input logic pe);
        logic [CFG_IDX_W-1:0]  idx  [4];
        logic [CFG_DATA_W-1:0] vals [4];
        int k;
        idx  = '{CFG_IMAGE_WIDTH, CFG_LINE_BYTES, CFG_IMAGE_HEIGHT, CFG_PALETTE_ENABLE};
        vals = '{w, lb, h, {15'b0, pe}};
        for (k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.note_config(idx[k], vals[k]);
        end
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Mostly well-formed literals and run pairs with random content; the rest are
    // palette writes and runs with a palette write wedged between header and value.
    task automatic random_burst(input int n);
        int target;
        int r;
        logic [RUN_W-1:0] cnt;
        target = items_sent + n;
        while (items_sent < target) begin
            r   = $urandom_range(0, 99);
            cnt = ($urandom_range(0, 7) == 0) ? RUN_W'($urandom_range(0, 63))
                                              : RUN_W'($urandom_range(0, 8));
            if (r < 50) begin
                send_run(cnt, 8'($urandom));
            end else if (r < 85) begin
                send_byte(8'($urandom_range(0, RUN_HDR_MIN - 1)), 1'b0);
            end else if (r < 93) begin
                send_palette(8'($urandom), 24'($urandom));
            end else begin
                send_byte(RUN_HDR_MIN | {2'b00, cnt}, 1'b0);
                send_palette(8'($urandom), 24'($urandom));
                send_byte(8'($urandom), 1'b0);
            end
        end
    endtask

    initial begin : stimulus
        int p;
        int i;
        int pick;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] lb;
        logic [COORD_W-1:0] h;
        logic [RUN_W-1:0]   cnt;
        string ending;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Gray output, literal extremes, zero run, a literal in padding and a
        // 63-byte run in padding, cut off at the scanline end.
        load_regs(16'd5, 16'd8, 16'hFFFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'(RUN_HDR_MIN - 1), 1'b0);
        send_run(6'd0, 8'h55);
        send_run(6'd3, 8'h12);
        send_byte(8'h07, 1'b0);
        send_run(6'h3F, 8'hAA);
        send_run(6'd4, 8'hFF);

        // Palette writes at both index extremes, then every entry so later lookups
        // only ever touch written entries.
        send_palette(8'hFF, 24'h000000);
        send_palette(8'h00, 24'hFFFFFF);
        for (i = 0; i < PAL_ENTRIES; i++)
            send_palette(8'(i), (i == 0) ? 24'hFFFFFF : (i == 1) ? 24'h000000
                                                               : 24'($urandom));

        settle();
        load_regs(16'd3, 16'd4, 16'hFFFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_run(6'd5, 8'hFF);

        // Zero width: every position is padding.
        settle();
        load_regs(16'd0, 16'd3, 16'hFFFF, 1'b1);
        send_run(6'd5, 8'h10);
        send_byte(8'h20, 1'b0);

        // Zero line_bytes behaves as one byte per scanline.
        settle();
        load_regs(16'd2, 16'd0, 16'hFFFF, 1'b0);
        send_run(6'd9, 8'h33);
        send_byte(8'h44, 1'b0);

        // line_bytes below width: every position is visible.
        settle();
        load_regs(16'd6, 16'd2, 16'hFFFF, 1'b1);
        send_run(6'd7, 8'h66);

        // Shrinking line_bytes mid-scanline ends the line at the next byte.
        settle();
        load_regs(16'd20, 16'd20, 16'hFFFF, 1'b0);
        for (i = 0; i < 4; i++)
            send_byte(8'($urandom_range(0, RUN_HDR_MIN - 1)), 1'b0);
        settle();
        load_regs(16'd20, 16'd3, 16'hFFFF, 1'b0);
        send_byte(8'h12, 1'b0);

        for (p = 0; p < PHASES; p++) begin
            settle();
            pick = $urandom_range(0, 7);
            case (pick)
                0: begin w = 16'd0;     lb = 16'($urandom_range(1, 6)); end
                1: begin w = 16'($urandom_range(1, 8)); lb = 16'd0; end
                2: begin w = 16'($urandom_range(4, 12)); lb = 16'($urandom_range(1, 3)); end
                3: begin w = 16'hFFFF;  lb = 16'hFFFF; end
                4: begin w = 16'd1;     lb = 16'd1; end
                default: begin
                    w  = 16'($urandom_range(1, 16));
                    lb = w + 16'($urandom_range(0, 5));
                end
            endcase
            h = (p == 0) ? 16'hFFFF : 16'($urandom_range(60000, 65535));
            load_regs(w, lb, h, 1'($urandom_range(0, 1)));
            steady <= (p == 2);
            if (p == 5)
                -> hold_kick;
            random_burst(PHASE_ITEMS);
        end
        steady <= 1'b0;

        // The image ends once per run, chosen at random: either end_of_data cuts it
        // short, or a zero height makes the current scanline the last one.
        if ($urandom_range(0, 1) == 1) begin
            ending = "truncation";
            random_burst(6);
            cnt  = RUN_W'($urandom_range(0, 63));
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
                send_byte(RUN_HDR_MIN | {2'b00, cnt}, 1'b1);
            end else if (pick == 1) begin
                send_byte(8'($urandom_range(0, RUN_HDR_MIN - 1)), 1'b1);
            end else begin
                send_byte(RUN_HDR_MIN | {2'b00, cnt}, 1'b0);
                send_byte(8'($urandom), 1'b1);
            end
        end else begin
            ending = "completion";
            settle();
            load_regs(16'd4, 16'd6, 16'd0, 1'($urandom_range(0, 1)));
            send_run(6'h3F, 8'($urandom));
        end

        // Once halted, pixel bytes change nothing and yield nothing.
        for (i = 0; i < 8; i++) begin
            if (i % 3 == 2)
                send_palette(8'($urandom), 24'($urandom));
            else
                send_byte(8'($urandom), 1'($urandom));
        end

        settle();
        $display("Checked %0d pixels and %0d truncation results from %0d input transactions.",
                 sb.pixels_seen, sb.truncs_seen, items_sent);
        $display("Used %0d register settings incl. degenerate sizes; the image ended by %s.",
                 settings_applied, ending);
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
sv/pcxrle_pkg.sv
sv/pcxrle_ram.sv
sv/pcx_rle_scanline_palette_decoder_core.sv
sv/pcxrle_checker.sv
test/pcx_rle_scanline_palette_decoder_core_tb.sv
